/* hw/rtl/bad_pixel_mean_fill_top_defines.svh */
// Assertion macros shared by the bad pixel fill RTL.
`ifndef BAD_PIXEL_MEAN_FILL_TOP_DEFINES_SVH
`define BAD_PIXEL_MEAN_FILL_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside of reset.
`define BPMF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bpmf assertion failed");
// Check a property on every clock edge, reset included.
`define BPMF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bpmf assertion failed");
`else
`define BPMF_ASSERT(lbl, clk, rstn, prop)
`define BPMF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/bpmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bpmf_pkg;

  localparam int PIXEL_COUNT = 4096;
  localparam int ADDR_W      = $clog2(PIXEL_COUNT);
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int FRAC_W      = 16;
  localparam int DVD_W       = ACC_W + FRAC_W;
  localparam int DIV_CNT_W   = $clog2(DVD_W);

  // Opcodes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ACCUM   = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // Result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_ZERO_FLUX = 2'd1;
  localparam logic [1:0] STS_OVERFLOW  = 2'd2;

  // Multiplier operand select
  localparam logic [1:0] MUL_VAL_FLUX  = 2'd0;
  localparam logic [1:0] MUL_FLUX_FLUX = 2'd1;
  localparam logic [1:0] MUL_FLUX_MEAN = 2'd2;

  // Divider operand select
  localparam logic DIV_PROD = 1'b0;
  localparam logic DIV_MEAN = 1'b1;

  typedef struct packed {
    logic              load;
    logic              mem_rd;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              div_start;
    logic              div_sel;
    logic              cap_term;
    logic              cap_ivar;
    logic              cap_mean;
    logic              acc_wr;
    logic              repl_upd;
    logic              clr_op;
    logic              clr_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       flux_zero;
    logic       good;
    logic       bad;
    logic       div_done;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/bpmf_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pixel input channel
interface bpmf_pix_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [11:0]              pixel_addr;
  logic signed [31:0]       pixel_value;
  logic [31:0]              pixel_variance;
  logic [31:0]              pixel_mask;
  logic signed [31:0]       image_flux;
  modport source (output valid, opcode, pixel_addr, pixel_value, pixel_variance,
                  pixel_mask, image_flux, input ready);
  modport sink (input valid, opcode, pixel_addr, pixel_value, pixel_variance,
                pixel_mask, image_flux, output ready);
endinterface

// Result channel
interface bpmf_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_out;
  logic               was_replaced;
  logic [31:0]        max_change;
  logic [1:0]         status;
  modport source (output valid, pixel_out, was_replaced, max_change, status,
                  input ready);
  modport sink (input valid, pixel_out, was_replaced, max_change, status,
                output ready);
endinterface

// Configuration write channel
interface bpmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] bad_mask;
  modport source (output valid, bad_mask, input ready);
  modport sink (input valid, bad_mask, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpmf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "bad_pixel_mean_fill_top_defines.svh"
module bpmf_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bpmf_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [bpmf_pkg::ACC_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [bpmf_pkg::DVD_W-1:0]       quotient_o
);

  localparam int DW = bpmf_pkg::DVD_W;
  localparam int RW = bpmf_pkg::ACC_W;
  localparam logic [bpmf_pkg::DIV_CNT_W-1:0] LAST = bpmf_pkg::DIV_CNT_W'(DW - 1);

  logic [DW-1:0] dvd_q;
  logic [RW-1:0] rem_q, rem_d, den_q;
  logic [bpmf_pkg::DIV_CNT_W-1:0] cnt_q;
  logic busy_q, done_q;
  logic [RW:0] rem_sh, rem_sub;
  logic qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = (rem_sh >= {1'b0, den_q});
    rem_d   = qbit ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) busy_q <= 1'b0;
      end
    end
  end

  // Quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  `BPMF_ASSERT(a_div_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `BPMF_ASSERT(a_div_no_restart, clk_i, rst_ni, busy_q |-> !start_i)
  `BPMF_ASSERT_ALWAYS(a_div_idle_in_reset, clk_i, !rst_ni |=> !busy_q || rst_ni)

endmodule
`default_nettype wire

/* hw/rtl/bpmf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module bpmf_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bpmf_pkg::cmd_t     cmd_i,
  output bpmf_pkg::sts_t          sts_o,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_bad_mask_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [11:0]        pixel_addr_i,
  input  wire logic signed [31:0] pixel_value_i,
  input  wire logic [31:0]        pixel_variance_i,
  input  wire logic [31:0]        pixel_mask_i,
  input  wire logic signed [31:0] image_flux_i,
  output logic signed [31:0]      pixel_out_o,
  output logic                    was_replaced_o,
  output logic [31:0]             max_change_o,
  output logic [1:0]              status_o
);

  localparam int AW = bpmf_pkg::ADDR_W;
  localparam int SW = bpmf_pkg::ACC_W;
  localparam int FW = bpmf_pkg::FRAC_W;

  // Pixel stores
  logic [SW-1:0] sum_mem [bpmf_pkg::PIXEL_COUNT];
  logic [SW-1:0] wgt_mem [bpmf_pkg::PIXEL_COUNT];

  logic [31:0] bad_mask_q, largest_q;
  logic [1:0]  op_q;
  logic [AW-1:0] addr_q;
  logic [31:0] val_q, var_q, flux_q;
  logic        bad_q;
  logic [SW-1:0] sum_rd_q, wgt_rd_q;
  logic [63:0] mul_q;
  logic [30:0] term_q, mean_q;
  logic [31:0] ivar_q;
  logic        term_ovf_q, ivar_ovf_q, neg_q, ovf_q;
  logic [31:0] pix_q;
  logic        repl_q;
  logic signed [31:0] pix_out_q;
  logic        repl_out_q;
  logic [31:0] max_out_q;
  logic [1:0]  sts_out_q;

  logic [31:0] abs_val, abs_flux, mul_a, mul_b;
  logic [bpmf_pkg::DVD_W-1:0] div_dvd, quot;
  logic [SW-1:0] div_den, abs_sum, t64;
  logic div_done;
  logic [SW:0] sum65, wgt65;
  logic acc_ovf;
  logic we;
  logic [AW-1:0] wa;
  logic [SW-1:0] wsum, wwgt;
  logic rneg;
  logic [47:0] pmag;
  logic [31:0] nv, delta;
  logic [32:0] diff;
  logic [1:0] sts_code;

  // Operand magnitudes
  always_comb begin
    abs_val  = val_q[31] ? (32'd0 - val_q) : val_q;
    abs_flux = flux_q[31] ? (32'd0 - flux_q) : flux_q;
    abs_sum  = sum_rd_q[SW-1] ? ({SW{1'b0}} - sum_rd_q) : sum_rd_q;
  end

  // Multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      bpmf_pkg::MUL_VAL_FLUX:  begin mul_a = abs_val;  mul_b = abs_flux; end
      bpmf_pkg::MUL_FLUX_FLUX: begin mul_a = abs_flux; mul_b = abs_flux; end
      bpmf_pkg::MUL_FLUX_MEAN: begin mul_a = abs_flux; mul_b = {1'b0, mean_q}; end
      default:                 begin mul_a = abs_flux; mul_b = abs_flux; end
    endcase
  end

  // Divider operand select
  always_comb begin
    if (cmd_i.div_sel == bpmf_pkg::DIV_MEAN) begin
      div_dvd = {abs_sum, {FW{1'b0}}};
      div_den = wgt_rd_q;
    end else begin
      div_dvd = {{FW{1'b0}}, mul_q};
      div_den = {32'd0, var_q};
    end
  end

  bpmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Accumulate: signed sum and unsigned weight with overflow checks
  always_comb begin
    t64     = neg_q ? ({SW{1'b0}} - {33'd0, term_q}) : {33'd0, term_q};
    sum65   = {sum_rd_q[SW-1], sum_rd_q} + {t64[SW-1], t64};
    wgt65   = {1'b0, wgt_rd_q} + {33'd0, ivar_q};
    acc_ovf = term_ovf_q || ivar_ovf_q || (sum65[SW] != sum65[SW-1]) || wgt65[SW];
  end

  // Replace: scaled mean, saturated, and change against the input value
  always_comb begin
    rneg = (mean_q != 31'd0) && (sum_rd_q[SW-1] != flux_q[31]);
    pmag = mul_q[63:FW];
    if (rneg) nv = (pmag > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - pmag[31:0]);
    else      nv = (pmag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : pmag[31:0];
    diff  = {nv[31], nv} - {val_q[31], val_q};
    delta = diff[32] ? (32'd0 - diff[31:0]) : diff[31:0];
  end

  // Store write port
  always_comb begin
    we   = 1'b0;
    wa   = addr_q;
    wsum = '0;
    wwgt = '0;
    if (cmd_i.clr_wr) begin
      we = 1'b1;
      wa = cmd_i.clr_addr;
    end else if (cmd_i.clr_op) begin
      we = 1'b1;
    end else if (cmd_i.acc_wr && !acc_ovf) begin
      we   = 1'b1;
      wsum = sum65[SW-1:0];
      wwgt = wgt65[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      sum_mem[wa] <= wsum;
      wgt_mem[wa] <= wwgt;
    end
    if (cmd_i.mem_rd) begin
      sum_rd_q <= sum_mem[addr_q];
      wgt_rd_q <= wgt_mem[addr_q];
    end
  end

  // Configuration and running maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_mask_q <= '0;
      largest_q  <= '0;
    end else begin
      if (cfg_we_i) bad_mask_q <= cfg_bad_mask_i;
      if (cmd_i.clr_op) largest_q <= '0;
      else if (cmd_i.repl_upd && (delta > largest_q)) largest_q <= delta;
    end
  end

  always_comb begin
    if (flux_q == 32'd0 && (op_q == bpmf_pkg::OP_ACCUM || op_q == bpmf_pkg::OP_REPLACE))
      sts_code = bpmf_pkg::STS_ZERO_FLUX;
    else if (ovf_q)
      sts_code = bpmf_pkg::STS_OVERFLOW;
    else
      sts_code = bpmf_pkg::STS_OK;
  end

  // Item payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      addr_q <= pixel_addr_i[AW-1:0];
      val_q  <= pixel_value_i;
      var_q  <= pixel_variance_i;
      flux_q <= image_flux_i;
      bad_q  <= |(pixel_mask_i & bad_mask_q);
      neg_q  <= pixel_value_i[31] != image_flux_i[31];
      pix_q  <= pixel_value_i;
      repl_q <= 1'b0;
      ovf_q  <= 1'b0;
    end
    if (cmd_i.mul_en) mul_q <= mul_a * mul_b;
    if (cmd_i.cap_term) begin
      term_q     <= quot[30:0];
      term_ovf_q <= |quot[bpmf_pkg::DVD_W-1:31];
    end
    if (cmd_i.cap_ivar) begin
      ivar_q     <= quot[31:0];
      ivar_ovf_q <= |quot[bpmf_pkg::DVD_W-1:32];
    end
    if (cmd_i.cap_mean) begin
      if (wgt_rd_q == '0)                   mean_q <= '0;
      else if (|quot[bpmf_pkg::DVD_W-1:31]) mean_q <= 31'h7FFF_FFFF;
      else                                  mean_q <= quot[30:0];
    end
    if (cmd_i.acc_wr) ovf_q <= acc_ovf;
    if (cmd_i.repl_upd) begin
      pix_q  <= nv;
      repl_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      pix_out_q  <= pix_q;
      repl_out_q <= repl_q;
      max_out_q  <= largest_q;
      sts_out_q  <= sts_code;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.flux_zero = (flux_q == 32'd0);
  assign sts_o.good      = !bad_q && (var_q != 32'd0);
  assign sts_o.bad       = bad_q;
  assign sts_o.div_done  = div_done;

  assign pixel_out_o    = pix_out_q;
  assign was_replaced_o = repl_out_q;
  assign max_change_o   = max_out_q;
  assign status_o       = sts_out_q;

endmodule
`default_nettype wire

/* hw/rtl/bpmf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "bad_pixel_mean_fill_top_defines.svh"
module bpmf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bpmf_pkg::cmd_t      cmd_o,
  input  wire bpmf_pkg::sts_t sts_i
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MUL_A = 4'd4;
  localparam logic [3:0] S_GO_A  = 4'd5;
  localparam logic [3:0] S_WT_A  = 4'd6;
  localparam logic [3:0] S_MUL_B = 4'd7;
  localparam logic [3:0] S_GO_B  = 4'd8;
  localparam logic [3:0] S_WT_B  = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_GO_M  = 4'd11;
  localparam logic [3:0] S_WT_M  = 4'd12;
  localparam logic [3:0] S_MUL_C = 4'd13;
  localparam logic [3:0] S_REPL  = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  localparam int AW = bpmf_pkg::ADDR_W;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_cnt_q;
  logic          out_valid_q;

  // Next state and datapath commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_cnt_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (clr_cnt_q == AW'(bpmf_pkg::PIXEL_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts_i.op == bpmf_pkg::OP_CLEAR) begin
          cmd_o.clr_op = 1'b1;
          state_d      = S_FIN;
        end else if (sts_i.flux_zero) begin
          state_d = S_FIN;
        end else if (sts_i.op == bpmf_pkg::OP_ACCUM && sts_i.good) begin
          state_d = S_RD;
        end else if (sts_i.op == bpmf_pkg::OP_REPLACE && sts_i.bad) begin
          state_d = S_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = (sts_i.op == bpmf_pkg::OP_ACCUM) ? S_MUL_A : S_GO_M;
      end
      S_MUL_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bpmf_pkg::MUL_VAL_FLUX;
        state_d       = S_GO_A;
      end
      S_GO_A: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bpmf_pkg::DIV_PROD;
        state_d         = S_WT_A;
      end
      S_WT_A: begin
        if (sts_i.div_done) begin
          cmd_o.cap_term = 1'b1;
          state_d        = S_MUL_B;
        end
      end
      S_MUL_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bpmf_pkg::MUL_FLUX_FLUX;
        state_d       = S_GO_B;
      end
      S_GO_B: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bpmf_pkg::DIV_PROD;
        state_d         = S_WT_B;
      end
      S_WT_B: begin
        if (sts_i.div_done) begin
          cmd_o.cap_ivar = 1'b1;
          state_d        = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_wr = 1'b1;
        state_d      = S_FIN;
      end
      S_GO_M: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bpmf_pkg::DIV_MEAN;
        state_d         = S_WT_M;
      end
      S_WT_M: begin
        if (sts_i.div_done) begin
          cmd_o.cap_mean = 1'b1;
          state_d        = S_MUL_C;
        end
      end
      S_MUL_C: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = bpmf_pkg::MUL_FLUX_MEAN;
        state_d       = S_REPL;
      end
      S_REPL: begin
        cmd_o.repl_upd = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, clearing sweep and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_o.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `BPMF_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `BPMF_ASSERT(a_no_accept_in_sweep, clk_i, rst_ni, (state_q == S_CLR) |-> !in_ready_o)
  `BPMF_ASSERT(a_result_held, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o)

endmodule
`default_nettype wire

/* hw/rtl/bad_pixel_mean_fill_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bad pixel fill by inverse-variance weighted mean, Q16.16 fixed point. After reset the
// block sweeps both 4096-entry stores to zero, one entry a cycle, before it takes its
// first pixel; configuration writes are taken at any time. One pixel is worked at a
// time, and the shared 80-step restoring divider sets the pace: a clear or a pass-through
// item needs no divide, a replace one and an accumulate two, and a finished pixel waits
// to be loaded into the output while the result there is held off.
// A finished result sits in an output register, so the next pixel is taken while it waits.
module bad_pixel_mean_fill_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpmf_pix_if.sink   pix_i,
  bpmf_res_if.source res_o,
  bpmf_cfg_if.sink   cfg_i
);

  bpmf_pkg::cmd_t cmd;
  bpmf_pkg::sts_t sts;

  // Configuration is always taken
  assign cfg_i.ready = 1'b1;

  bpmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bpmf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_i.valid),
    .cfg_bad_mask_i   (cfg_i.bad_mask),
    .opcode_i         (pix_i.opcode),
    .pixel_addr_i     (pix_i.pixel_addr),
    .pixel_value_i    (pix_i.pixel_value),
    .pixel_variance_i (pix_i.pixel_variance),
    .pixel_mask_i     (pix_i.pixel_mask),
    .image_flux_i     (pix_i.image_flux),
    .pixel_out_o      (res_o.pixel_out),
    .was_replaced_o   (res_o.was_replaced),
    .max_change_o     (res_o.max_change),
    .status_o         (res_o.status)
  );

endmodule
`default_nettype wire
